### rtl/fifo_with_running_statistics_macros.svh
// assertion macros for the top-level rtl file
`ifndef FIFO_WITH_RUNNING_STATISTICS_MACROS_SVH
`define FIFO_WITH_RUNNING_STATISTICS_MACROS_SVH

`ifndef SYNTH
// same-cycle implication
`define FWRS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("fwrs assertion failed");
// next-cycle implication
`define FWRS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("fwrs assertion failed");
`else
`define FWRS_ASSERT_NOW(label, ante, cons)
`define FWRS_ASSERT_NEXT(label, ante, cons)
`endif

`endif

### rtl/fwrs_pkg.sv
package fwrs_pkg;

    localparam int unsigned DEPTH_DEF  = 4;
    localparam int unsigned VAL_W      = 32;
    localparam int unsigned MODE_W     = 2;
    localparam int unsigned STAT_W     = 2;
    localparam int unsigned CNT_OUT_W  = 3;
    localparam int unsigned TOT_W      = 34;
    localparam int unsigned AVG_W      = 40;
    localparam int unsigned FRAC_W     = 8;
    localparam int unsigned IN_DATA_W  = 32;
    localparam int unsigned OUT_PAD_W  = 3;
    localparam int unsigned OUT_DATA_W =
        VAL_W + CNT_OUT_W + TOT_W + VAL_W + VAL_W + AVG_W + OUT_PAD_W;

    localparam logic [MODE_W-1:0] MODE_PUSH  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_POP   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

    localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_STAT,
        S_DIV,
        S_OUT
    } t_state;

    typedef struct packed {
        logic load;
        logic shift;
    } t_cell_ctl;

endpackage

### rtl/fwrs_cell.sv
module fwrs_cell #(
    parameter int unsigned IDX   = 0,
    parameter int unsigned CNT_W = 3,
    parameter int unsigned SUM_W = 34
) (
    input  logic                              i_clk,
    input  fwrs_pkg::t_cell_ctl               i_ctl,
    input  logic [CNT_W-1:0]                  i_count,
    input  logic signed [fwrs_pkg::VAL_W-1:0] i_push_value,
    input  logic signed [fwrs_pkg::VAL_W-1:0] i_next_entry,
    output logic signed [fwrs_pkg::VAL_W-1:0] o_entry,
    input  logic                              i_part_any,
    input  logic signed [SUM_W-1:0]           i_part_sum,
    input  logic signed [fwrs_pkg::VAL_W-1:0] i_part_min,
    input  logic signed [fwrs_pkg::VAL_W-1:0] i_part_max,
    output logic                              o_part_any,
    output logic signed [SUM_W-1:0]           o_part_sum,
    output logic signed [fwrs_pkg::VAL_W-1:0] o_part_min,
    output logic signed [fwrs_pkg::VAL_W-1:0] o_part_max
);
    import fwrs_pkg::*;

    logic signed [VAL_W-1:0] r_entry, n_entry;
    logic                    r_part_any, n_part_any;
    logic signed [SUM_W-1:0] r_part_sum, n_part_sum;
    logic signed [VAL_W-1:0] r_part_min, n_part_min;
    logic signed [VAL_W-1:0] r_part_max, n_part_max;
    logic                    w_active;

    assign w_active = CNT_W'(IDX) < i_count;

    // push lands in the first free cell, pop moves everything one cell toward the head
    always_comb begin
        n_entry = r_entry;
        if (i_ctl.load && (i_count == CNT_W'(IDX))) begin
            n_entry = i_push_value;
        end else if (i_ctl.shift) begin
            n_entry = i_next_entry;
        end
    end

    // running sum, min and max flow one cell per cycle toward the tail
    always_comb begin
        n_part_any = i_part_any;
        n_part_sum = i_part_sum;
        n_part_min = i_part_min;
        n_part_max = i_part_max;
        if (w_active) begin
            n_part_any = 1'b1;
            n_part_sum = i_part_sum + SUM_W'(r_entry);
            n_part_min = (!i_part_any || (r_entry < i_part_min)) ? r_entry : i_part_min;
            n_part_max = (!i_part_any || (r_entry > i_part_max)) ? r_entry : i_part_max;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry    <= n_entry;
        r_part_any <= n_part_any;
        r_part_sum <= n_part_sum;
        r_part_min <= n_part_min;
        r_part_max <= n_part_max;
    end

    assign o_entry    = r_entry;
    assign o_part_any = r_part_any;
    assign o_part_sum = r_part_sum;
    assign o_part_min = r_part_min;
    assign o_part_max = r_part_max;

endmodule

### rtl/fwrs_div.sv
module fwrs_div #(
    parameter int unsigned NUM_W = 42,
    parameter int unsigned DEN_W = 3
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic signed [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0]        i_den,
    output logic                    o_done,
    output logic signed [NUM_W-1:0] o_quot
);
    import fwrs_pkg::*;

    localparam int unsigned STEP_W = $clog2(NUM_W + 1);

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [STEP_W-1:0] r_step, n_step;
    logic              r_neg, n_neg;
    logic [NUM_W-1:0]  r_num, n_num;
    logic [DEN_W-1:0]  r_rem, n_rem;
    logic [DEN_W-1:0]  r_den, n_den;
    logic [DEN_W:0]    w_trial;
    logic [DEN_W:0]    w_diff;
    logic              w_fit;
    logic [NUM_W-1:0]  w_mag;

    assign w_mag   = i_num[NUM_W-1] ? NUM_W'(-i_num) : NUM_W'(i_num);
    assign w_trial = {r_rem, r_num[NUM_W-1]};
    assign w_fit   = w_trial >= {1'b0, r_den};
    assign w_diff  = w_trial - {1'b0, r_den};

    // restoring division, one quotient bit a cycle shifted in behind the dividend
    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_step = r_step;
        n_neg  = r_neg;
        n_num  = r_num;
        n_rem  = r_rem;
        n_den  = r_den;
        if (i_start) begin
            n_busy = 1'b1;
            n_step = '0;
            n_neg  = i_num[NUM_W-1];
            n_num  = w_mag;
            n_rem  = '0;
            n_den  = i_den;
        end else if (r_busy) begin
            n_rem  = w_fit ? w_diff[DEN_W-1:0] : w_trial[DEN_W-1:0];
            n_num  = {r_num[NUM_W-2:0], w_fit};
            n_step = r_step + STEP_W'(1);
            if (r_step == STEP_W'(NUM_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_step <= n_step;
        end
        r_neg <= n_neg;
        r_num <= n_num;
        r_rem <= n_rem;
        r_den <= n_den;
    end

    assign o_done = r_done;
    assign o_quot = r_neg ? signed'(NUM_W'(-r_num)) : signed'(r_num);

endmodule

### rtl/fifo_with_running_statistics.sv
// Queue of up to DEPTH signed 32-bit values held in a row of cells, oldest at cell 0.
// Each transfer on the input asks for a push, a pop or a clear (tuser) and produces exactly
// one result transfer with a status, the popped value and the count, sum, minimum, maximum
// and q8 average of the entries still held. One item is processed at a time: the queue is
// updated, the statistics then sweep down the cell row, and the average comes from a serial
// divider producing one bit per cycle over max(34, 32 + clog2(DEPTH)) + 8 bits, which is
// skipped when the queue is empty.
// A finished result waits in an output register, so the next item can be accepted
// before the previous result is taken.
module fifo_with_running_statistics #(
    parameter int unsigned DEPTH = fwrs_pkg::DEPTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // [31:0] push_value
    input  logic [fwrs_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // [1:0] mode
    input  logic [fwrs_pkg::MODE_W-1:0]        s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [31:0] popped_value, [34:32] entry_count, [68:35] total, [100:69] minimum,
    // [132:101] maximum, [172:133] average_q8, [175:173] zero
    output logic [fwrs_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    // [1:0] status
    output logic [fwrs_pkg::STAT_W-1:0]        m_axis_tuser
);
    import fwrs_pkg::*;

    `include "fifo_with_running_statistics_macros.svh"

    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam int unsigned SCN_W = $clog2(DEPTH + 1);
    localparam int unsigned SUM_W =
        (VAL_W + $clog2(DEPTH) > TOT_W) ? (VAL_W + $clog2(DEPTH)) : TOT_W;
    localparam int unsigned NUM_W = SUM_W + FRAC_W;

    t_state                  r_state, n_state;
    logic [CNT_W-1:0]        r_count, n_count;
    logic [SCN_W-1:0]        r_scan, n_scan;
    logic [STAT_W-1:0]       r_status, n_status;
    logic signed [VAL_W-1:0] r_popped, n_popped;
    logic                    r_out_valid, n_out_valid;
    logic [OUT_DATA_W-1:0]   r_out_data, n_out_data;
    logic [STAT_W-1:0]       r_out_user, n_out_user;

    logic                    w_accept;
    logic [MODE_W-1:0]       w_mode;
    logic signed [VAL_W-1:0] w_push_value;
    t_cell_ctl               w_ctl;
    logic                    w_ready;
    logic                    w_div_start;
    logic                    w_out_load;
    logic                    w_div_done;
    logic signed [NUM_W-1:0] w_quot;
    logic                    w_has;
    logic                    w_push_full;

    logic signed [VAL_W-1:0] w_entry [DEPTH];
    logic                    w_any   [DEPTH+1];
    logic signed [SUM_W-1:0] w_sum   [DEPTH+1];
    logic signed [VAL_W-1:0] w_min   [DEPTH+1];
    logic signed [VAL_W-1:0] w_max   [DEPTH+1];

    logic signed [TOT_W-1:0] w_total;
    logic signed [VAL_W-1:0] w_minimum;
    logic signed [VAL_W-1:0] w_maximum;
    logic signed [AVG_W-1:0] w_average;

    assign w_mode       = s_axis_tuser;
    assign w_push_value = signed'(s_axis_tdata[VAL_W-1:0]);
    assign w_accept     = s_axis_tvalid && w_ready;
    assign w_has        = r_count != '0;
    assign w_push_full  = w_accept && (w_mode == MODE_PUSH) && (r_count == CNT_W'(DEPTH));

    // cell row
    assign w_any[0] = 1'b0;
    assign w_sum[0] = '0;
    assign w_min[0] = '0;
    assign w_max[0] = '0;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic signed [VAL_W-1:0] w_next;
        if (g == DEPTH - 1) begin : g_tail
            assign w_next = w_entry[g];
        end else begin : g_mid
            assign w_next = w_entry[g+1];
        end
        fwrs_cell #(
            .IDX   (g),
            .CNT_W (CNT_W),
            .SUM_W (SUM_W)
        ) u_cell (
            .i_clk        (i_clk),
            .i_ctl        (w_ctl),
            .i_count      (r_count),
            .i_push_value (w_push_value),
            .i_next_entry (w_next),
            .o_entry      (w_entry[g]),
            .i_part_any   (w_any[g]),
            .i_part_sum   (w_sum[g]),
            .i_part_min   (w_min[g]),
            .i_part_max   (w_max[g]),
            .o_part_any   (w_any[g+1]),
            .o_part_sum   (w_sum[g+1]),
            .o_part_min   (w_min[g+1]),
            .o_part_max   (w_max[g+1])
        );
    end

    fwrs_div #(
        .NUM_W (NUM_W),
        .DEN_W (CNT_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   ({w_sum[DEPTH], FRAC_W'(0)}),
        .i_den   (r_count),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    // queue update on an accepted transfer
    always_comb begin
        w_ctl    = '0;
        n_count  = r_count;
        n_status = r_status;
        n_popped = r_popped;
        if (w_accept) begin
            n_status = ST_DONE;
            n_popped = '0;
            case (w_mode)
                MODE_PUSH: begin
                    if (r_count >= CNT_W'(DEPTH)) begin
                        n_status = ST_FULL;
                    end else begin
                        w_ctl.load = 1'b1;
                        n_count    = r_count + CNT_W'(1);
                    end
                end
                MODE_POP: begin
                    if (!w_has) begin
                        n_status = ST_EMPTY;
                    end else begin
                        w_ctl.shift = 1'b1;
                        n_popped    = w_entry[0];
                        n_count     = r_count - CNT_W'(1);
                    end
                end
                MODE_CLEAR: begin
                    if (!w_has) begin
                        n_status = ST_EMPTY;
                    end else begin
                        n_count = '0;
                    end
                end
                default: begin
                    n_status = ST_DONE;
                end
            endcase
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_scan == SCN_W'(DEPTH - 1)) begin
                    n_state = S_STAT;
                end
            end
            S_STAT: begin
                n_state = w_has ? S_DIV : S_OUT;
            end
            S_DIV: begin
                if (w_div_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (w_out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb begin
        w_ready     = 1'b0;
        w_div_start = 1'b0;
        w_out_load  = 1'b0;
        case (r_state)
            S_IDLE: w_ready     = 1'b1;
            S_STAT: w_div_start = w_has;
            S_OUT:  w_out_load  = !r_out_valid || m_axis_tready;
            default: begin
                w_ready = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_scan = r_scan;
        if (w_accept) begin
            n_scan = '0;
        end else if (r_state == S_SCAN) begin
            n_scan = r_scan + SCN_W'(1);
        end
    end

    // result assembly, statistics are zero on an empty queue
    assign w_total   = w_has ? w_sum[DEPTH][TOT_W-1:0] : '0;
    assign w_minimum = w_has ? w_min[DEPTH] : '0;
    assign w_maximum = w_has ? w_max[DEPTH] : '0;
    assign w_average = w_has ? w_quot[AVG_W-1:0] : '0;

    always_comb begin
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        n_out_user  = r_out_user;
        if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end
        if (w_out_load) begin
            n_out_valid = 1'b1;
            n_out_data  = {OUT_PAD_W'(0), w_average, w_maximum, w_minimum, w_total,
                           CNT_OUT_W'(r_count), r_popped};
            n_out_user  = r_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_scan      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_scan      <= n_scan;
            r_out_valid <= n_out_valid;
        end
        r_status   <= n_status;
        r_popped   <= n_popped;
        r_out_data <= n_out_data;
        r_out_user <= n_out_user;
    end

    assign s_axis_tready = w_ready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

    `FWRS_ASSERT_NOW(a_count_range, 1'b1, r_count <= CNT_W'(DEPTH))
    `FWRS_ASSERT_NEXT(a_full_refused, w_push_full, (r_status == ST_FULL) && $stable(r_count))
    `FWRS_ASSERT_NOW(a_div_done_in_div, w_div_done, r_state == S_DIV)
    `FWRS_ASSERT_NEXT(a_result_not_overwritten, (r_state == S_OUT) && r_out_valid && !m_axis_tready, (r_state == S_OUT) && $stable(r_out_data))

endmodule

### sim/fifo_with_running_statistics_test.sv
module fifo_with_running_statistics_test;
    timeunit 1ns;
    timeprecision 1ps;

    import fwrs_pkg::*;

    localparam int unsigned QDEPTH     = DEPTH_DEF;
    localparam logic [MODE_W-1:0] MODE_NOP = 2'd3;
    localparam int unsigned RAND_ITEMS = 925;
    localparam longint      CYCLE_CAP  = 1_000_000;
    localparam int unsigned SETTLE     = 80;
    localparam longint      MAXV       = 64'sd2147483647;
    localparam longint      MINV       = -64'sd2147483648;
    localparam longint      AVG_TOP    = 64'sd549755813632;

    typedef struct packed {
        logic [STAT_W-1:0]           status;
        logic signed [VAL_W-1:0]     popped;
        logic [CNT_OUT_W-1:0]        count;
        logic signed [TOT_W-1:0]     total;
        logic signed [VAL_W-1:0]     lo;
        logic signed [VAL_W-1:0]     hi;
        logic signed [AVG_W-1:0]     avg;
    } t_q_stats;

    typedef struct {
        logic [MODE_W-1:0]    mode;
        logic [VAL_W-1:0]     value;
        bit                   typed;
        t_q_stats             want;
    } t_plan_row;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic s_axis_tvalid;
    logic s_axis_tready;
    // [31:0] push_value
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    // [1:0] mode
    logic [MODE_W-1:0]     s_axis_tuser;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    // [31:0] popped_value, [34:32] entry_count, [68:35] total, [100:69] minimum,
    // [132:101] maximum, [172:133] average_q8, [175:173] zero
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    // [1:0] status
    logic [STAT_W-1:0]     m_axis_tuser;

    fifo_with_running_statistics #(
        .DEPTH(QDEPTH)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // shadow copy of the queue contents
    logic signed [VAL_W-1:0] held [QDEPTH];
    int                      fill = 0;

    t_q_stats    pending_stats [$];
    t_plan_row   plan [$];
    int          errors = 0;
    longint      cycles = 0;
    int          results_seen = 0;
    int          seen_at_neg = 0;
    int          stall_next = 0;
    int          hold_left = 0;
    int          stall_left = 0;
    bit          hold_used = 1'b0;
    bit          rx_quiet = 1'b0;
    bit          tx_quiet = 1'b0;
    t_q_stats    got_stats;
    t_q_stats    want_stats;

    function automatic t_q_stats stats_of(logic [STAT_W-1:0] st, longint pv, longint cnt,
                                          longint tot, longint lo, longint hi, longint av);
        t_q_stats r;
        r.status = st;
        r.popped = pv[VAL_W-1:0];
        r.count  = cnt[CNT_OUT_W-1:0];
        r.total  = tot[TOT_W-1:0];
        r.lo     = lo[VAL_W-1:0];
        r.hi     = hi[VAL_W-1:0];
        r.avg    = av[AVG_W-1:0];
        return r;
    endfunction

    // apply one request to the shadow queue and work out the statistics it reports
    function automatic t_q_stats apply_request(logic [MODE_W-1:0] mode,
                                               logic signed [VAL_W-1:0] value);
        t_q_stats                r;
        longint                  sum;
        longint                  mean;
        logic signed [VAL_W-1:0] lo;
        logic signed [VAL_W-1:0] hi;
        r = '0;
        r.status = ST_DONE;
        case (mode)
            MODE_PUSH: begin
                if (fill >= int'(QDEPTH)) begin
                    r.status = ST_FULL;
                end else begin
                    held[fill] = value;
                    fill++;
                end
            end
            MODE_POP: begin
                if (fill == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.popped = held[0];
                    for (int i = 0; i + 1 < fill; i++) held[i] = held[i + 1];
                    fill--;
                end
            end
            MODE_CLEAR: begin
                if (fill == 0) r.status = ST_EMPTY;
                else fill = 0;
            end
            default: ;
        endcase
        r.count = fill[CNT_OUT_W-1:0];
        if (fill > 0) begin
            sum = 0;
            lo = held[0];
            hi = held[0];
            for (int i = 0; i < fill; i++) begin
                sum += held[i];
                if (held[i] < lo) lo = held[i];
                if (held[i] > hi) hi = held[i];
            end
            // signed division truncates toward zero
            mean = (sum * 256) / fill;
            r.total = sum[TOT_W-1:0];
            r.lo    = lo;
            r.hi    = hi;
            r.avg   = mean[AVG_W-1:0];
        end
        return r;
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int gap_len(bit quiet);
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 15);
        return $urandom_range(20, 80);
    endfunction

    function automatic logic [VAL_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return 32'($urandom_range(0, 20)) - 32'd10;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [MODE_W-1:0] pick_mode();
        int r;
        r = $urandom_range(0, 99);
        if (r < 46) return MODE_PUSH;
        if (r < 80) return MODE_POP;
        if (r < 91) return MODE_CLEAR;
        return MODE_NOP;
    endfunction

    task automatic add_row(logic [MODE_W-1:0] mode, logic [VAL_W-1:0] value, bit typed,
                           t_q_stats want);
        t_plan_row row;
        row.mode  = mode;
        row.value = value;
        row.typed = typed;
        row.want  = want;
        plan.push_back(row);
    endtask

    task automatic report(string what, t_q_stats want, t_q_stats got);
        errors++;
        if (errors <= 10)
            $display("%s: want st=%0d pop=%0d cnt=%0d sum=%0d lo=%0d hi=%0d avg=%0d",
                     what, want.status, want.popped, want.count, want.total, want.lo,
                     want.hi, want.avg,
                     " | got st=%0d pop=%0d cnt=%0d sum=%0d lo=%0d hi=%0d avg=%0d",
                     got.status, got.popped, got.count, got.total,
                     got.lo, got.hi, got.avg);
    endtask

    // called at a falling edge, returns at the falling edge after the transfer
    task automatic send_item(logic [MODE_W-1:0] mode, logic [VAL_W-1:0] value, bit typed,
                             t_q_stats want, bit drain);
        int       g;
        t_q_stats predicted;
        g = gap_len(tx_quiet);
        if (drain) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= $urandom;
            @(negedge i_clk);
            while (pending_stats.size() != 0) @(negedge i_clk);
        end else if (g > 0) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= $urandom;
            s_axis_tuser  <= MODE_W'($urandom);
            repeat (g) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        s_axis_tuser  <= mode;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predicted = apply_request(mode, value);
        pending_stats.push_back(typed ? want : predicted);
        @(negedge i_clk);
    endtask

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_CAP) begin
            $display("tb: failure");
            $finish;
        end
    end

    // result side: check each transfer and pick the next stall
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got_stats.popped = m_axis_tdata[31:0];
            got_stats.count  = m_axis_tdata[34:32];
            got_stats.total  = m_axis_tdata[68:35];
            got_stats.lo     = m_axis_tdata[100:69];
            got_stats.hi     = m_axis_tdata[132:101];
            got_stats.avg    = m_axis_tdata[172:133];
            got_stats.status = m_axis_tuser;
            if (pending_stats.size() == 0) begin
                report("unexpected result", '0, got_stats);
            end else begin
                want_stats = pending_stats.pop_front();
                if (got_stats !== want_stats) report("mismatch", want_stats, got_stats);
            end
            results_seen++;
            stall_next = gap_len(rx_quiet);
            if (results_seen % 48 == 0) rx_quiet = ($urandom_range(0, 3) == 0);
        end
    end

    // receiver ready, with one long hold-off so the block backs up and stalls its input
    always @(negedge i_clk) begin
        if (results_seen != seen_at_neg) begin
            seen_at_neg = results_seen;
            stall_left  = stall_next;
            if (results_seen >= 150 && !hold_used) begin
                hold_used = 1'b1;
                hold_left = 400;
            end
        end
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            m_axis_tready <= 1'b0;
            hold_left--;
        end else if (stall_left > 0) begin
            m_axis_tready <= 1'b0;
            stall_left--;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    initial begin
        int                n;
        int                k;
        logic [MODE_W-1:0] mode;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = MODE_PUSH;
        for (int i = 0; i < int'(QDEPTH); i++) held[i] = '0;

        // empty queue refusals and the unused mode
        add_row(MODE_POP,   32'h0,         1, stats_of(ST_EMPTY, 0, 0, 0, 0, 0, 0));
        add_row(MODE_CLEAR, 32'h0,         1, stats_of(ST_EMPTY, 0, 0, 0, 0, 0, 0));
        add_row(MODE_NOP,   32'hffff_ffff, 1, stats_of(ST_DONE, 0, 0, 0, 0, 0, 0));
        // fill with the largest value, then push into a full queue
        add_row(MODE_PUSH,  32'h7fff_ffff, 1, stats_of(ST_DONE, 0, 1, MAXV, MAXV, MAXV,
                                                       AVG_TOP));
        add_row(MODE_PUSH,  32'h7fff_ffff, 0, '0);
        add_row(MODE_PUSH,  32'h7fff_ffff, 0, '0);
        add_row(MODE_PUSH,  32'h7fff_ffff, 1, stats_of(ST_DONE, 0, 4, 64'sd8589934588, MAXV,
                                                       MAXV, AVG_TOP));
        add_row(MODE_PUSH,  32'h5,         1, stats_of(ST_FULL, 0, 4, 64'sd8589934588, MAXV,
                                                       MAXV, AVG_TOP));
        add_row(MODE_POP,   32'h0,         0, '0);
        add_row(MODE_CLEAR, 32'h0,         1, stats_of(ST_DONE, 0, 0, 0, 0, 0, 0));
        // fill with the smallest value
        add_row(MODE_PUSH,  32'h8000_0000, 0, '0);
        add_row(MODE_PUSH,  32'h8000_0000, 0, '0);
        add_row(MODE_PUSH,  32'h8000_0000, 0, '0);
        add_row(MODE_PUSH,  32'h8000_0000, 1, stats_of(ST_DONE, 0, 4, -64'sd8589934592, MINV,
                                                       MINV, -64'sd549755813888));
        add_row(MODE_NOP,   32'h1234_5678, 0, '0);
        add_row(MODE_CLEAR, 32'h0,         1, stats_of(ST_DONE, 0, 0, 0, 0, 0, 0));
        // negative mean that must truncate toward zero
        add_row(MODE_PUSH,  32'hffff_ffff, 0, '0);
        add_row(MODE_PUSH,  32'h0,         0, '0);
        add_row(MODE_PUSH,  32'h0,         0, '0);
        add_row(MODE_PUSH,  32'h5,         0, '0);
        add_row(MODE_POP,   32'h0,         0, '0);
        add_row(MODE_POP,   32'h0,         0, '0);
        add_row(MODE_POP,   32'h0,         0, '0);
        add_row(MODE_POP,   32'h0,         1, stats_of(ST_DONE, 5, 0, 0, 0, 0, 0));
        add_row(MODE_POP,   32'h0,         1, stats_of(ST_EMPTY, 0, 0, 0, 0, 0, 0));

        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (plan[i]) send_item(plan[i].mode, plan[i].value, plan[i].typed,
                                    plan[i].want, 1'b0);

        n = 0;
        k = 0;
        while (n < RAND_ITEMS) begin
            if (k % 64 == 0) tx_quiet = ($urandom_range(0, 3) == 0);
            mode = pick_mode();
            send_item(mode, pick_value(), 1'b0, '0, k == 400);
            n++;
            k++;
        end
        s_axis_tvalid <= 1'b0;

        while (pending_stats.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
        if (errors == 0 && pending_stats.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
